// ----- rtl/core/notch_lms_sinusoid_canceller_macros.svh -----
// Assertion macros shared by the canceller RTL.
`ifndef NOTCH_LMS_SINUSOID_CANCELLER_MACROS_SVH
`define NOTCH_LMS_SINUSOID_CANCELLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NLSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nlsc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NLSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nlsc assertion failed");

`endif

// ----- rtl/core/nlsc_pkg.sv -----
package nlsc_pkg;

   localparam int MUL_A_BITS = 40;
   localparam int MUL_B_BITS = 33;
   localparam int MUL_P_BITS = MUL_A_BITS + 1 + MUL_B_BITS;
   localparam int MUL_CNT_BITS = 6;

   typedef logic signed [MUL_A_BITS-1:0] mul_a_type;
   typedef logic signed [MUL_B_BITS-1:0] mul_b_type;
   typedef logic signed [MUL_P_BITS-1:0] mul_p_type;

   localparam logic [31:0] K1 = 32'd1686629713;
   localparam logic [31:0] K3 = 32'd693598668;
   localparam logic [31:0] K5 = 32'd85569306;
   localparam logic [31:0] K7 = 32'd5026995;
   localparam logic [31:0] K9 = 32'd172272;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOTCH_COS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_SIZE = 2'd2;
   localparam logic [15:0] STEP_SIZE_RESET = 16'd6554;

endpackage

// ----- rtl/core/nlsc_serial_mul.sv -----
module nlsc_serial_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  nlsc_pkg::mul_a_type a,
   input  nlsc_pkg::mul_b_type b,
   output logic               done,
   output nlsc_pkg::mul_p_type product
);

   localparam int AB = nlsc_pkg::MUL_A_BITS;
   localparam int BB = nlsc_pkg::MUL_B_BITS;
   localparam int CB = nlsc_pkg::MUL_CNT_BITS;

   nlsc_pkg::mul_a_type a_ff;
   logic [BB-1:0] b_ff, b_in;
   logic signed [AB:0] hi_ff, hi_in;
   logic [BB-1:0] lo_ff, lo_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic done_ff, done_in;
   logic signed [AB+1:0] a_ext, addend, sum;

   always_comb begin
      a_ext = (AB+2)'(a_ff);
      if (!b_ff[0]) begin
         addend = '0;
      end else if (cnt_ff == CB'(1)) begin
         addend = -a_ext;
      end else begin
         addend = a_ext;
      end
      sum = (AB+2)'(hi_ff) + addend;
      hi_in = hi_ff;
      lo_in = lo_ff;
      b_in = b_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         hi_in = '0;
         lo_in = '0;
         b_in = b;
         cnt_in = CB'(BB);
      end else if (cnt_ff != '0) begin
         hi_in = sum[AB+1:1];
         lo_in = {sum[0], lo_ff[BB-1:1]};
         b_in = {1'b0, b_ff[BB-1:1]};
         cnt_in = cnt_ff - CB'(1);
         done_in = (cnt_ff == CB'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      if (start) begin
         a_ff <= a;
      end
      b_ff <= b_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

// ----- rtl/core/notch_lms_sinusoid_canceller.sv -----
// Channel | Direction | Ports                                   | Beat
// req     | in        | req_valid/ready, sample, block_start    | one audio sample
// rsp     | out       | rsp_valid/ready, error_sample           | one error sample
// csr     | in        | csr_write_enable, csr_index, csr_data   | one register write
// Each sample takes 19 passes of a bit-serial multiplier, each pass a load and a
// wait state of the sequencer, with the idle and done states around the sample.
// Reset is synchronous, active high, and resets the state and the CSRs.
// A new sample is taken only when the sequencer is idle; one finished result
// may wait in the output register while the next sample is being worked on.
`include "notch_lms_sinusoid_canceller_macros.svh"

module notch_lms_sinusoid_canceller #(
   parameter int SAMPLE_BITS = 16,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample,
   input  logic                                   req_block_start,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]          rsp_error_sample,
   input  logic                                   csr_write_enable,
   input  logic [nlsc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [nlsc_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   localparam int SH = 31 - SAMPLE_BITS;
   localparam int L = $clog2(SINE_TABLE_DEPTH);
   localparam int PB = nlsc_pkg::MUL_P_BITS;
   localparam int AB = nlsc_pkg::MUL_A_BITS;
   localparam int BB = nlsc_pkg::MUL_B_BITS;
   localparam int EB = 36;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOAD = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam logic [2:0] P_UU = 3'd0;
   localparam logic [2:0] P_K9 = 3'd1;
   localparam logic [2:0] P_R5 = 3'd2;
   localparam logic [2:0] P_R3 = 3'd3;
   localparam logic [2:0] P_R1 = 3'd4;
   localparam logic [2:0] P_RU = 3'd5;

   localparam logic [4:0] OP_POLY_HALF = 5'd6;
   localparam logic [4:0] OP_POLY_END = 5'd11;
   localparam logic [4:0] OP_NOTCH = 5'd12;
   localparam logic [4:0] OP_ACOS = 5'd13;
   localparam logic [4:0] OP_BSIN = 5'd14;
   localparam logic [4:0] OP_ECOS = 5'd15;
   localparam logic [4:0] OP_MUA = 5'd16;
   localparam logic [4:0] OP_ESIN = 5'd17;
   localparam logic [4:0] OP_MUB = 5'd18;

   logic [1:0] state_ff, state_in;
   logic [4:0] op_ff, op_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, d1_ff, d2_ff;
   logic signed [31:0] cw_ff, sw_ff;
   logic [31:0] phase_ff, phase_step_ff;
   logic signed [15:0] notch_cos_ff;
   logic [15:0] step_size_ff;
   logic [30:0] w_ff;
   logic [31:0] r_ff;
   logic [15:0] s0_ff, s1_ff;
   logic signed [EB-1:0] y_ff, acc_ff, e_ff;
   logic signed [AB-1:0] t_ff;
   logic rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff;

   nlsc_pkg::mul_a_type mul_a;
   nlsc_pkg::mul_b_type mul_b;
   nlsc_pkg::mul_p_type prod;
   logic mul_start, mul_done;

   logic [L-1:0] idx;
   logic [1:0] q_s, q_c;
   logic [30:0] u0, u1, u_sel;
   logic half;
   logic [2:0] sub;
   logic [31:0] prod_hi;
   logic [17:0] rounded;
   logic [15:0] s_val;
   logic signed [15:0] cv, sv;
   logic signed [PB-1:0] notch_term, wide_tmp;
   logic signed [EB-1:0] y_new, shat;
   logic signed [40:0] w_sum;
   logic signed [31:0] w_sat;
   logic signed [EB-1:0] e_shift;
   logic signed [SAMPLE_BITS-1:0] o_sat;
   logic finish;

   nlsc_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (prod)
   );

   function automatic logic signed [15:0] quarter_pick(logic [1:0] q, logic [15:0] sa,
                                                        logic [15:0] sb);
      logic signed [15:0] v;
      v = q[0] ? sb : sa;
      return q[1] ? -v : v;
   endfunction

   always_comb begin
      idx = phase_ff[31 -: L];
      q_s = idx[L-1 -: 2];
      q_c = q_s + 2'd1;
      u0 = 31'(idx[L-3:0]) << (32 - L);
      u1 = 31'(32'd1 << 30) - u0;
      half = (op_ff >= OP_POLY_HALF);
      sub = half ? 3'(op_ff - OP_POLY_HALF) : op_ff[2:0];
      u_sel = half ? u1 : u0;
      cv = quarter_pick(q_c, s0_ff, s1_ff);
      sv = quarter_pick(q_s, s0_ff, s1_ff);

      mul_a = '0;
      mul_b = '0;
      if (op_ff <= OP_POLY_END) begin
         case (sub)
            P_UU: begin
               mul_a = AB'(u_sel);
               mul_b = BB'(u_sel);
            end
            P_K9: begin
               mul_a = AB'(nlsc_pkg::K9);
               mul_b = BB'(w_ff);
            end
            P_RU: begin
               mul_a = AB'(r_ff);
               mul_b = BB'(u_sel);
            end
            default: begin
               mul_a = AB'(r_ff);
               mul_b = BB'(w_ff);
            end
         endcase
      end else begin
         case (op_ff)
            OP_NOTCH: begin
               mul_a = AB'(notch_cos_ff);
               mul_b = BB'(d1_ff);
            end
            OP_ACOS: begin
               mul_a = AB'(cw_ff);
               mul_b = BB'(cv);
            end
            OP_BSIN: begin
               mul_a = AB'(sw_ff);
               mul_b = BB'(sv);
            end
            OP_ECOS: begin
               mul_a = AB'(e_ff);
               mul_b = BB'(cv);
            end
            OP_ESIN: begin
               mul_a = AB'(e_ff);
               mul_b = BB'(sv);
            end
            default: begin
               mul_a = t_ff;
               mul_b = BB'({1'b0, step_size_ff});
            end
         endcase
      end

      prod_hi = prod[61:30];
      rounded = 18'((33'(prod_hi) + 33'd16384) >> 15);
      s_val = (rounded > 18'd32767) ? 16'd32767 : rounded[15:0];

      notch_term = (prod <<< SH) >>> 14;
      y_new = EB'((PB'(x_ff) <<< SH) - notch_term + (PB'(d2_ff) <<< SH));
      wide_tmp = prod >>> 15;
      shat = acc_ff + EB'(wide_tmp);
      w_sum = (op_ff == OP_MUA ? 41'(cw_ff) : 41'(sw_ff)) + 41'(prod >>> 16);
      if (w_sum > 41'sd2147483647) begin
         w_sat = 32'sh7fffffff;
      end else if (w_sum < -41'sd2147483648) begin
         w_sat = 32'sh80000000;
      end else begin
         w_sat = w_sum[31:0];
      end

      e_shift = e_ff >>> SH;
      if (e_shift > EB'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1)) begin
         o_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else if (e_shift < -EB'(64'sd1 <<< (SAMPLE_BITS - 1))) begin
         o_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         o_sat = e_shift[SAMPLE_BITS-1:0];
      end

      finish = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
      mul_start = (state_ff == S_LOAD);
      state_in = state_ff;
      op_in = op_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOAD;
               op_in = '0;
            end
         end
         S_LOAD: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (mul_done) begin
               if (op_ff == OP_MUB) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_LOAD;
                  op_in = op_ff + 5'd1;
               end
            end
         end
         default: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= '0;
         rsp_valid_ff <= 1'b0;
         d1_ff <= '0;
         d2_ff <= '0;
         cw_ff <= '0;
         sw_ff <= '0;
         phase_ff <= '0;
         notch_cos_ff <= '0;
         phase_step_ff <= '0;
         step_size_ff <= nlsc_pkg::STEP_SIZE_RESET;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            case (csr_index)
               nlsc_pkg::CSR_NOTCH_COS: notch_cos_ff <= csr_data[15:0];
               nlsc_pkg::CSR_PHASE_STEP: phase_step_ff <= csr_data;
               nlsc_pkg::CSR_STEP_SIZE: step_size_ff <= csr_data[15:0];
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready && req_block_start) begin
            phase_ff <= '0;
         end else if (finish) begin
            phase_ff <= phase_ff + phase_step_ff;
         end
         if (finish) begin
            d2_ff <= d1_ff;
            d1_ff <= x_ff;
         end
         if ((state_ff == S_WAIT) && mul_done) begin
            if (op_ff == OP_MUA) begin
               cw_ff <= w_sat;
            end
            if (op_ff == OP_MUB) begin
               sw_ff <= w_sat;
            end
         end
      end
      if (req_valid && req_ready) begin
         x_ff <= req_sample;
      end
      if (finish) begin
         rsp_data_ff <= o_sat;
      end
      if ((state_ff == S_WAIT) && mul_done) begin
         if (op_ff <= OP_POLY_END) begin
            case (sub)
               P_UU: w_ff <= prod[60:30];
               P_K9: r_ff <= nlsc_pkg::K7 - prod_hi;
               P_R5: r_ff <= nlsc_pkg::K5 - prod_hi;
               P_R3: r_ff <= nlsc_pkg::K3 - prod_hi;
               P_R1: r_ff <= nlsc_pkg::K1 - prod_hi;
               default: begin
                  if (half) begin
                     s1_ff <= s_val;
                  end else begin
                     s0_ff <= s_val;
                  end
               end
            endcase
         end else begin
            case (op_ff)
               OP_NOTCH: y_ff <= y_new;
               OP_ACOS: acc_ff <= EB'(wide_tmp);
               OP_BSIN: e_ff <= y_ff - shat;
               OP_ECOS: t_ff <= AB'(wide_tmp);
               OP_ESIN: t_ff <= AB'(wide_tmp);
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_error_sample = rsp_data_ff;

   `NLSC_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)
   `NLSC_ASSERT_SAME(a_done_in_wait, clock, reset, mul_done, state_ff == S_WAIT)
   `NLSC_ASSERT_SAME(a_op_range, clock, reset, state_ff != S_IDLE, op_ff <= OP_MUB)
   `NLSC_ASSERT_NEXT(a_hold_done, clock, reset,
      (state_ff == S_DONE) && rsp_valid_ff && !rsp_ready, state_ff == S_DONE)

endmodule
